FILE: design/drm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg
// Shared types and constants of the downward region allocator.
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 25;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int SHIFT_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [SHIFT_W-1:0] ALIGN_RESET      = 5'd5;
  localparam logic [SHIFT_W-1:0] ALIGN_MAX        = 5'd16;
  localparam logic [ADDR_W-1:0]  HEAP_TOP_RESET   = 32'h8120_0000;
  localparam logic [ADDR_W-1:0]  TABLE_BASE_RESET = 32'h8150_0000;
  localparam logic [ADDR_W-1:0]  ADDR_LOW_MASK    = 32'h3FFF_FFFF;
  localparam logic [ADDR_W-1:0]  CACHED_SEGMENT   = 32'h8000_0000;

  localparam logic [FUNC_W-1:0] FN_ALLOC    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC_AT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FREE     = 2'd2;
  localparam logic [FUNC_W-1:0] FN_UNUSED   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

FILE: design/drm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface drm_req_if;
  import drm_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] req_address;
  modport source (output valid, func, req_size, req_address, input ready);
  modport sink   (input valid, func, req_size, req_address, output ready);
endinterface

interface drm_rsp_if;
  import drm_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic [STAT_W-1:0] status;
  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

FILE: design/drm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_mem
// Region table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module drm_mem (
  input  logic                         clk,
  input  drm_pkg::mem_wr_t             wr,
  input  logic [drm_pkg::IDX_W-1:0]    raddr,
  output drm_pkg::entry_t              rdata
);
  import drm_pkg::*;

  entry_t mem [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/drm_ovl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_ovl
// Shared half-open interval overlap test against one table entry.
// ----------------------------------------------------------------------------
module drm_ovl (
  input  logic [drm_pkg::ADDR_W-1:0] cand_start,
  input  logic [drm_pkg::SIZE_W-1:0] cand_size,
  input  drm_pkg::entry_t            ent,
  output logic                       hit
);
  import drm_pkg::*;

  logic [ADDR_W:0] cand_end;
  logic [ADDR_W:0] ent_end;

  // ends carry one extra bit so regions past the top compare correctly
  assign cand_end = {1'b0, cand_start} + {{(ADDR_W+1-SIZE_W){1'b0}}, cand_size};
  assign ent_end  = {1'b0, ent.start} + {{(ADDR_W+1-SIZE_W){1'b0}}, ent.size};
  assign hit = ({1'b0, cand_start} < ent_end) && ({1'b0, ent.start} < cand_end);

endmodule

FILE: design/downward_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downward_region_allocator
// Region table allocator growing down from heap_top, with a sequencer that
// walks the table through one overlap comparator.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ch.ready is high only while the sequencer
// is idle. Every table entry is visited through the single read port of the
// table memory, each visit an address and then registered data. Free walks
// every live entry once; allocate-at checks its one candidate against the
// entries until one overlaps; allocate scans candidates in table order and
// checks each against all entries. Requests that are decided up front (table
// full, size too big after rounding, unused func) go straight to the result.
// The result sits in an output register, so a new item can be taken while it
// waits. After reset, and after a table_base write, the sentinel entry is
// written before the next item is taken.
// ----------------------------------------------------------------------------
module downward_region_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  drm_req_if.sink                         in_ch,
  drm_rsp_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [drm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drm_pkg::ADDR_W-1:0]      cfg_data
);
  import drm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ORD  = 3'd1;  // outer scan: issue read
  localparam logic [2:0] S_OCHK = 3'd2;  // outer scan: candidate from entry
  localparam logic [2:0] S_IRD  = 3'd3;  // overlap scan: issue read
  localparam logic [2:0] S_ICHK = 3'd4;  // overlap scan: compare
  localparam logic [2:0] S_FRD  = 3'd5;  // free: issue read
  localparam logic [2:0] S_FCHK = 3'd6;  // free: keep or drop
  localparam logic [2:0] S_FIN  = 3'd7;  // publish result, append entry

  // control
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             init_r, init_nxt;
  logic             oval_r, oval_nxt;
  logic [SHIFT_W-1:0] align_r, align_nxt;
  logic [ADDR_W-1:0]  heap_top_r, heap_top_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  // work registers
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [ADDR_W-1:0] cand_r, cand_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0] low_r, low_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic              add_r, add_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;

  mem_wr_t          wr;
  logic [IDX_W-1:0] raddr;
  entry_t           rd;
  logic             hit;

  // size rounding
  logic [SHIFT_W-1:0] sh;
  logic [SIZE_W:0]    amask;
  logic [SIZE_W:0]    rsize;

  assign sh    = (align_r > ALIGN_MAX) ? ALIGN_MAX : align_r;
  assign amask = ({{SIZE_W{1'b0}}, 1'b1} << sh) - {{SIZE_W{1'b0}}, 1'b1};
  assign rsize = ({1'b0, in_ch.req_size} + amask) & ~amask;

  drm_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rd)
  );

  drm_ovl u_ovl (
    .cand_start (cand_r),
    .cand_size  (size_r),
    .ent        (rd),
    .hit        (hit)
  );

  assign in_ch.ready           = (state_r == S_IDLE) && !init_r;
  assign out_ch.valid          = oval_r;
  assign out_ch.result_address = oaddr_r;
  assign out_ch.status         = ostat_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    init_nxt     = init_r;
    oval_nxt     = oval_r;
    align_nxt    = align_r;
    heap_top_nxt = heap_top_r;
    base_nxt     = base_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cand_nxt     = cand_r;
    size_nxt     = size_r;
    low_nxt      = low_r;
    func_nxt     = func_r;
    add_nxt      = add_r;
    st_nxt       = st_r;
    oaddr_nxt    = oaddr_r;
    ostat_nxt    = ostat_r;
    wr           = '0;
    raddr        = i_r[IDX_W-1:0];

    if (oval_r && out_ch.ready) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (init_r) begin
          wr.we    = 1'b1;
          wr.addr  = '0;
          wr.data  = '{start: base_r, size: '0};
          init_nxt = 1'b0;
        end else if (in_ch.valid) begin
          func_nxt = in_ch.func;
          size_nxt = rsize[SIZE_W-1:0];
          add_nxt  = 1'b0;
          st_nxt   = ST_OK;
          i_nxt    = '0;
          j_nxt    = '0;
          low_nxt  = heap_top_r;
          cand_nxt = in_ch.req_address;
          state_nxt = S_FIN;
          if (in_ch.func == FN_ALLOC || in_ch.func == FN_ALLOC_AT) begin
            if (count_r >= CNT_W'(MAX_REGIONS)) begin
              st_nxt = ST_FULL;
            end else if (rsize[SIZE_W]) begin
              st_nxt = ST_REFUSED;
            end else if (in_ch.func == FN_ALLOC_AT) begin
              cand_nxt  = (in_ch.req_address & ADDR_LOW_MASK) | CACHED_SEGMENT;
              state_nxt = S_IRD;
            end else begin
              state_nxt = S_ORD;
            end
          end else if (in_ch.func == FN_FREE) begin
            state_nxt = S_FRD;
          end
        end
      end
      S_ORD: begin
        raddr = i_r[IDX_W-1:0];
        if (i_r == count_r) begin
          // no candidate fit: drop below the lowest start or heap_top
          if (low_r >= {{(ADDR_W-SIZE_W){1'b0}}, size_r}) begin
            cand_nxt = low_r - {{(ADDR_W-SIZE_W){1'b0}}, size_r};
            add_nxt  = 1'b1;
          end else begin
            st_nxt = ST_REFUSED;
          end
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_OCHK;
        end
      end
      S_OCHK: begin
        if (rd.start < low_r) begin
          low_nxt = rd.start;
        end
        if (rd.start >= {{(ADDR_W-SIZE_W){1'b0}}, size_r}) begin
          cand_nxt  = rd.start - {{(ADDR_W-SIZE_W){1'b0}}, size_r};
          j_nxt     = '0;
          state_nxt = S_IRD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_ORD;
        end
      end
      S_IRD: begin
        raddr = j_r[IDX_W-1:0];
        if (j_r == count_r) begin
          add_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ICHK;
        end
      end
      S_ICHK: begin
        if (hit) begin
          if (func_r == FN_ALLOC) begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_ORD;
          end else begin
            st_nxt    = ST_REFUSED;
            state_nxt = S_FIN;
          end
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_IRD;
        end
      end
      S_FRD: begin
        raddr = i_r[IDX_W-1:0];
        if (i_r == count_r) begin
          st_nxt    = (j_r == count_r) ? ST_NONE : ST_OK;
          count_nxt = j_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        // compact survivors in place; j never passes i
        if ((rd.start & ADDR_LOW_MASK) != (cand_r & ADDR_LOW_MASK)) begin
          wr.we   = 1'b1;
          wr.addr = j_r[IDX_W-1:0];
          wr.data = rd;
          j_nxt   = j_r + CNT_W'(1);
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_FRD;
      end
      S_FIN: begin
        if (!oval_r) begin
          oval_nxt  = 1'b1;
          ostat_nxt = st_r;
          oaddr_nxt = add_r ? cand_r : '0;
          if (add_r) begin
            wr.we     = 1'b1;
            wr.addr   = count_r[IDX_W-1:0];
            wr.data   = '{start: cand_r, size: size_r};
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_ALIGN_SHIFT: align_nxt = cfg_data[SHIFT_W-1:0];
        CFG_HEAP_TOP:    heap_top_nxt = cfg_data;
        CFG_TABLE_BASE: begin
          base_nxt  = cfg_data;
          count_nxt = CNT_W'(1);
          init_nxt  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= CNT_W'(1);
      init_r     <= 1'b1;
      oval_r     <= 1'b0;
      align_r    <= ALIGN_RESET;
      heap_top_r <= HEAP_TOP_RESET;
      base_r     <= TABLE_BASE_RESET;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      init_r     <= init_nxt;
      oval_r     <= oval_nxt;
      align_r    <= align_nxt;
      heap_top_r <= heap_top_nxt;
      base_r     <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    cand_r  <= cand_nxt;
    size_r  <= size_nxt;
    low_r   <= low_nxt;
    func_r  <= func_nxt;
    add_r   <= add_nxt;
    st_r    <= st_nxt;
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
  end

endmodule
